[src/pt_pkg.sv]
// Shared types and constants for the piece table text store.
`timescale 1ns / 1ps
package pt_pkg;
    localparam int MaxPiecesDef = 64;
    localparam int OrigDepthDef = 4096;
    localparam int AddDepthDef  = 4096;
    localparam int PosW = 14;
    localparam int LenW = 17;

    typedef enum logic [1:0] {
        CMD_LOAD   = 2'd0,
        CMD_INSERT = 2'd1,
        CMD_ERASE  = 2'd2,
        CMD_READ   = 2'd3
    } t_cmd;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_RANGE = 2'd1,
        ST_FULL  = 2'd2,
        ST_EDIT  = 2'd3
    } t_status;

    // Piece record: source flag, logical start, byte offset, length.
    typedef struct packed {
        logic            from_add;
        logic [LenW-1:0] start;
        logic [LenW-1:0] offset;
        logic [LenW-1:0] length;
    } t_piece;

    // Chain control broadcast to every cell.
    typedef struct packed {
        logic            load0;   // grow cell 0 (or create it)
        logic            upd;     // apply edit
        logic [1:0]      shift;   // 0, 1 or 2 places up above the hit
        logic            inc;     // starts above the written cells move up by one
        logic            dec;     // starts above the written cells move down by one
        logic [10:0]     idx;     // hit cell
        t_piece          p0;      // new content for idx
        t_piece          p1;      // new content for idx+1
        t_piece          p2;      // new content for idx+2
        logic [1:0]      nwrite;  // how many of p0..p2 are written
    } t_ctl;
endpackage

[src/pt_cell.sv]
// One piece cell: holds a record and takes its neighbors' on a shift.
`timescale 1ns / 1ps
module pt_cell
    import pt_pkg::*;
#(
    parameter int Index = 0,
    parameter int IdxW  = 6
) (
    input  logic   i_clk,
    input  t_ctl   i_ctl,
    input  t_piece i_below1,
    input  t_piece i_below2,
    output t_piece o_piece
);
    t_piece r_piece;
    t_piece w_src;
    t_piece w_moved;
    logic [IdxW+1:0] w_me;
    logic [IdxW+1:0] w_idx;
    logic [IdxW+1:0] w_end;
    assign w_me  = (IdxW+2)'(Index);
    assign w_idx = (IdxW+2)'(i_ctl.idx[IdxW:0]);
    assign w_end = w_idx + (IdxW+2)'(i_ctl.nwrite);

    // Cells above the written ones keep their record or take a lower one,
    // with the start moved by the byte gained or lost.
    always_comb begin
        case (i_ctl.shift)
            2'd1:    w_src = i_below1;
            2'd2:    w_src = i_below2;
            default: w_src = r_piece;
        endcase
        w_moved = w_src;
        if (i_ctl.inc)      w_moved.start = w_src.start + LenW'(1);
        else if (i_ctl.dec) w_moved.start = w_src.start - LenW'(1);
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.load0 && Index == 0) begin
            r_piece <= i_ctl.p0;
        end else if (i_ctl.upd) begin
            if (w_me == w_idx && i_ctl.nwrite >= 2'd1) begin
                r_piece <= i_ctl.p0;
            end else if (w_me == w_idx + (IdxW+2)'(1) && i_ctl.nwrite >= 2'd2) begin
                r_piece <= i_ctl.p1;
            end else if (w_me == w_idx + (IdxW+2)'(2) && i_ctl.nwrite == 2'd3) begin
                r_piece <= i_ctl.p2;
            end else if (w_me >= w_end) begin
                r_piece <= w_moved;
            end
        end
    end
    assign o_piece = r_piece;
endmodule

[src/pt_locate.sv]
// Finds the piece under a position by comparing against every cell's start.
`timescale 1ns / 1ps
module pt_locate
    import pt_pkg::*;
#(
    parameter int MaxPieces = MaxPiecesDef,
    parameter int IdxW      = 6
) (
    input  t_piece                i_pieces [MaxPieces],
    input  logic [IdxW:0]         i_count,
    input  logic [PosW-1:0]       i_pos,
    input  logic [LenW-1:0]       i_total,
    output logic                  o_found,
    output logic [IdxW:0]         o_idx,
    output logic [LenW-1:0]       o_rem,
    output t_piece                o_hit
);
    logic [LenW-1:0]      w_pos;
    logic [MaxPieces-1:0] w_hit;

    // Nonempty pieces cover disjoint ranges, so at most one cell hits.
    always_comb begin
        w_pos = LenW'(i_pos);
        o_idx = '0;
        o_hit = '0;
        for (int i = 0; i < MaxPieces; i++) begin
            w_hit[i] = ((IdxW+1)'(i) < i_count) && (w_pos >= i_pieces[i].start)
                       && (w_pos < i_pieces[i].start + i_pieces[i].length);
            if (w_hit[i]) begin
                o_idx = o_idx | (IdxW+1)'(i);
                o_hit = t_piece'(o_hit | i_pieces[i]);
            end
        end
        o_found = |w_hit;
        if (o_found) begin
            o_rem = w_pos - o_hit.start;
        end else begin
            o_idx = i_count;
            o_rem = w_pos - i_total;
        end
    end
endmodule

[src/piece_table_text_store.sv]
// Top level of the piece table text store.
`timescale 1ns / 1ps
// Byte-wide piece table. Each input beat carries one command (load, insert,
// erase, read) and gives exactly one result beat with a status and a byte.
// Piece records live in a row of cells, each holding its logical start, so
// every cell compares the position in parallel. An edit that adds pieces
// shifts the cells above the hit piece up by one or two places, and every
// edit moves their starts by the byte gained or lost. After its beat is
// accepted, each command passes a find state (registered compare results)
// and then an execute state that applies the edit and accesses the byte
// memory. The result beat is registered as the execute state ends and is
// held until taken; a new command can be accepted at the same edge as the
// result is taken. One command is in flight at a time.
// Zero-length pieces are kept and skipped by every lookup.
module piece_table_text_store
    import pt_pkg::*;
#(
    parameter int MaxPieces = MaxPiecesDef,
    parameter int OrigDepth = OrigDepthDef,
    parameter int AddDepth  = AddDepthDef
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,  // command[1:0], position[15:2], byte_in[23:16]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata   // status[1:0], byte_out[9:2], zero[15:10]
);
    localparam int IdxW = $clog2(MaxPieces);
    localparam int OW   = $clog2(OrigDepth);
    localparam int AW   = $clog2(AddDepth);

    typedef enum logic [1:0] {S_IDLE, S_FIND, S_EXEC} t_state;
    t_state r_state;

    t_cmd            r_cmd;
    logic [PosW-1:0] r_pos;
    logic [7:0]      r_byte;
    logic [IdxW:0]   r_count;
    logic [OW:0]     r_olen;
    logic [AW:0]     r_alen;
    logic [LenW-1:0] r_total;
    logic            r_edited;
    logic            r_found;
    logic [IdxW:0]   r_idx;
    logic [LenW-1:0] r_rem;
    t_piece          r_hit;
    logic            r_rd, r_rd_add;
    logic [LenW-1:0] r_rd_addr;
    logic            r_ovalid;
    logic [1:0]      r_ostat;
    logic [7:0]      r_orig [OrigDepth];
    logic [7:0]      r_add  [AddDepth];
    logic [7:0]      r_rdata;

    t_piece w_pieces [MaxPieces];
    t_ctl   w_ctl;
    logic            w_found;
    logic [IdxW:0]   w_idx;
    logic [LenW-1:0] w_rem;
    t_piece          w_hit;
    logic [1:0]      w_stat;
    logic            w_owr, w_awr;
    logic [7:0]      w_obyte;
    logic [LenW-1:0] w_pos;

    // Input opens again at the edge where the waiting result is taken.
    assign s_axis_tready = (r_state == S_IDLE) && (!r_ovalid || m_axis_tready);
    assign m_axis_tvalid = r_ovalid;
    assign w_obyte       = r_rd ? r_rdata : 8'd0;
    assign m_axis_tdata  = {6'b0, w_obyte, r_ostat};
    assign w_pos         = LenW'(r_pos);

    pt_locate #(.MaxPieces(MaxPieces), .IdxW(IdxW)) u_loc (
        .i_pieces(w_pieces), .i_count(r_count), .i_pos(r_pos), .i_total(r_total),
        .o_found(w_found), .o_idx(w_idx), .o_rem(w_rem), .o_hit(w_hit)
    );

    for (genvar g = 0; g < MaxPieces; g++) begin : g_cell
        t_piece w_b1, w_b2;
        if (g >= 1) begin : g_b1
            assign w_b1 = w_pieces[g-1];
        end else begin : g_b1z
            assign w_b1 = '0;
        end
        if (g >= 2) begin : g_b2
            assign w_b2 = w_pieces[g-2];
        end else begin : g_b2z
            assign w_b2 = '0;
        end
        pt_cell #(.Index(g), .IdxW(IdxW)) u_cell (
            .i_clk(i_clk), .i_ctl(w_ctl), .i_below1(w_b1), .i_below2(w_b2),
            .o_piece(w_pieces[g])
        );
    end

    // Command decode in the execute cycle, from the registered lookup.
    always_comb begin
        t_piece fresh;
        fresh   = '{from_add: 1'b1, start: w_pos, offset: LenW'(r_alen),
                    length: LenW'(1)};
        w_ctl   = '0;
        w_ctl.idx = 11'(r_idx);
        w_stat  = ST_OK;
        w_owr   = 1'b0;
        w_awr   = 1'b0;
        if (r_state == S_EXEC) begin
            unique case (r_cmd)
                CMD_LOAD: begin
                    if (r_edited) w_stat = ST_EDIT;
                    else if (r_olen >= (OW+1)'(OrigDepth)) w_stat = ST_FULL;
                    else begin
                        w_owr = 1'b1;
                        w_ctl.load0 = 1'b1;
                        w_ctl.p0 = (r_count == '0) ?
                            '{from_add: 1'b0, start: '0, offset: '0, length: LenW'(1)} :
                            '{from_add: w_pieces[0].from_add, start: w_pieces[0].start,
                              offset: w_pieces[0].offset,
                              length: w_pieces[0].length + LenW'(1)};
                    end
                end
                CMD_INSERT: begin
                    if (!r_found && r_rem != '0) w_stat = ST_RANGE;
                    else if ((32'(r_count) + ((r_found && r_rem != '0) ? 32'd2 : 32'd1)
                              > 32'(MaxPieces)) || r_alen >= (AW+1)'(AddDepth))
                        w_stat = ST_FULL;
                    else begin
                        w_awr = 1'b1;
                        w_ctl.upd = 1'b1;
                        w_ctl.inc = 1'b1;
                        if (r_found && r_rem != '0) begin
                            // inside a piece: head, new byte, tail
                            w_ctl.shift  = 2'd2;
                            w_ctl.nwrite = 2'd3;
                            w_ctl.p0 = '{from_add: r_hit.from_add, start: r_hit.start,
                                         offset: r_hit.offset, length: r_rem};
                            w_ctl.p1 = fresh;
                            w_ctl.p2 = '{from_add: r_hit.from_add,
                                         start: w_pos + LenW'(1),
                                         offset: r_hit.offset + r_rem,
                                         length: r_hit.length - r_rem};
                        end else begin
                            w_ctl.shift  = 2'd1;
                            w_ctl.nwrite = 2'd1;
                            w_ctl.p0 = fresh;
                        end
                    end
                end
                CMD_ERASE: begin
                    if (!r_found) w_stat = ST_RANGE;
                    else if (r_rem == r_hit.length - LenW'(1)) begin
                        w_ctl.upd = 1'b1; w_ctl.nwrite = 2'd1; w_ctl.dec = 1'b1;
                        w_ctl.p0 = '{from_add: r_hit.from_add, start: r_hit.start,
                                     offset: r_hit.offset,
                                     length: r_hit.length - LenW'(1)};
                    end else if (r_rem == '0) begin
                        w_ctl.upd = 1'b1; w_ctl.nwrite = 2'd1; w_ctl.dec = 1'b1;
                        w_ctl.p0 = '{from_add: r_hit.from_add, start: r_hit.start,
                                     offset: r_hit.offset + LenW'(1),
                                     length: r_hit.length - LenW'(1)};
                    end else if (32'(r_count) + 32'd1 > 32'(MaxPieces)) w_stat = ST_FULL;
                    else begin
                        w_ctl.upd = 1'b1; w_ctl.shift = 2'd1; w_ctl.nwrite = 2'd2;
                        w_ctl.dec = 1'b1;
                        w_ctl.p0 = '{from_add: r_hit.from_add, start: r_hit.start,
                                     offset: r_hit.offset, length: r_rem};
                        w_ctl.p1 = '{from_add: r_hit.from_add, start: w_pos,
                                     offset: r_hit.offset + r_rem + LenW'(1),
                                     length: r_hit.length - r_rem - LenW'(1)};
                    end
                end
                CMD_READ: begin
                    if (!r_found) w_stat = ST_RANGE;
                end
                default: ;
            endcase
        end
    end

    // Byte memories; the read address is registered in the find cycle.
    always_ff @(posedge i_clk) begin
        if (w_owr) r_orig[r_olen[OW-1:0]] <= r_byte;
        if (w_awr) r_add[r_alen[AW-1:0]] <= r_byte;
    end
    always_ff @(posedge i_clk) begin
        if (r_state == S_EXEC) begin
            if (r_rd_add) r_rdata <= r_add[r_rd_addr[AW-1:0]];
            else          r_rdata <= r_orig[r_rd_addr[OW-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_count  <= '0;
            r_olen   <= '0;
            r_alen   <= '0;
            r_total  <= '0;
            r_edited <= 1'b0;
            r_ovalid <= 1'b0;
            r_rd     <= 1'b0;
            r_ostat  <= ST_OK;
        end else begin
            if (r_state == S_EXEC)  r_ovalid <= 1'b1;
            else if (m_axis_tready) r_ovalid <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (s_axis_tvalid && s_axis_tready) begin
                        r_cmd   <= t_cmd'(s_axis_tdata[1:0]);
                        r_pos   <= s_axis_tdata[15:2];
                        r_byte  <= s_axis_tdata[23:16];
                        r_state <= S_FIND;
                    end
                end
                S_FIND: begin
                    r_found   <= w_found;
                    r_idx     <= w_idx;
                    r_rem     <= w_rem;
                    r_hit     <= w_hit;
                    r_rd_add  <= w_hit.from_add;
                    r_rd_addr <= w_hit.offset + w_rem;
                    r_state   <= S_EXEC;
                end
                S_EXEC: begin
                    r_ostat <= w_stat;
                    r_rd    <= (r_cmd == CMD_READ) && (w_stat == ST_OK);
                    if (w_owr) r_olen <= r_olen + 1'b1;
                    if (w_awr) r_alen <= r_alen + 1'b1;
                    if (w_owr || w_awr)  r_total <= r_total + LenW'(1);
                    else if (w_ctl.upd)  r_total <= r_total - LenW'(1);
                    if (w_owr && r_count == '0) begin
                        r_count <= (IdxW+1)'(1);
                    end else if (w_ctl.upd) begin
                        r_count <= r_count + (IdxW+1)'(w_ctl.shift);
                    end
                    if (w_ctl.upd) r_edited <= 1'b1;
                    r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

`ifndef NO_ASSERTIONS
    a_count_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_count) <= MaxPieces) else $error("piece count overflow");
    a_one_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE) |-> !s_axis_tready) else $error("accept while busy");
    a_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EXEC) |=> r_ovalid) else $error("result lost");
`endif
endmodule

[tb/sv/tb_piece_table_text_store.sv]
// Testbench for the piece table text store: scoreboard class and stimulus.
`timescale 1ns / 1ps
module tb_piece_table_text_store;
    import pt_pkg::*;

    localparam int NumPieces  = MaxPiecesDef;
    localparam int OrigBytes  = OrigDepthDef;
    localparam int AddBytes   = AddDepthDef;
    localparam int FillBytes  = 300;
    localparam int RandItems  = 1330;
    localparam int IdleLimit  = 1500;
    localparam int LongStall  = 400;

    // Keeps its own piece list and byte stores, predicts each result beat.
    class text_scoreboard;
        logic [7:0] orig_mem[OrigBytes];
        logic [7:0] add_mem[AddBytes];
        bit         pc_add[NumPieces];
        int         pc_off[NumPieces];
        int         pc_len[NumPieces];
        int         n_pieces;
        int         orig_len;
        int         add_len;
        bit         edited;
        t_status    want_status[$];
        logic [7:0] want_byte[$];
        int         errors;
        int         results_seen;
        int         n_ok, n_range, n_full, n_edit;

        function new();
            n_pieces = 0; orig_len = 0; add_len = 0; edited = 0;
            errors = 0; results_seen = 0;
            n_ok = 0; n_range = 0; n_full = 0; n_edit = 0;
        endfunction

        function int text_len();
            int sum;
            sum = 0;
            for (int i = 0; i < n_pieces; i++) sum += pc_len[i];
            return sum;
        endfunction

        function int pending();
            return want_status.size();
        endfunction

        // Walk the pieces to a logical position; zero-length pieces fall through.
        function bit find_piece(input int pos, output int idx, output int rem);
            for (int i = 0; i < n_pieces; i++) begin
                if (pos < pc_len[i]) begin
                    idx = i; rem = pos;
                    return 1;
                end
                pos -= pc_len[i];
            end
            idx = n_pieces; rem = pos;
            return 0;
        endfunction

        function void open_gap(int idx, int by);
            for (int i = n_pieces - 1; i >= idx; i--) begin
                pc_add[i+by] = pc_add[i];
                pc_off[i+by] = pc_off[i];
                pc_len[i+by] = pc_len[i];
            end
        endfunction

        function void set_piece(int i, bit a, int off, int len);
            pc_add[i] = a; pc_off[i] = off; pc_len[i] = len;
        endfunction

        // Called once per accepted input beat.
        function void note_command(t_cmd cmd, int pos, logic [7:0] din);
            t_status    st;
            logic [7:0] dout;
            int         idx, rem, need;
            bit         hit;
            bit         oa;
            int         oo, ol;
            st = ST_OK;
            dout = 8'h00;
            case (cmd)
                CMD_LOAD: begin
                    if (edited) st = ST_EDIT;
                    else if (orig_len >= OrigBytes) st = ST_FULL;
                    else begin
                        orig_mem[orig_len] = din;
                        orig_len++;
                        if (n_pieces == 0) begin
                            set_piece(0, 0, 0, 1);
                            n_pieces = 1;
                        end else begin
                            pc_len[0]++;
                        end
                    end
                end
                CMD_INSERT: begin
                    hit = find_piece(pos, idx, rem);
                    if (!hit && rem != 0) st = ST_RANGE;
                    else begin
                        need = (hit && rem > 0) ? 2 : 1;
                        if (n_pieces + need > NumPieces || add_len >= AddBytes) st = ST_FULL;
                        else begin
                            add_mem[add_len] = din;
                            if (need == 2) begin
                                oa = pc_add[idx]; oo = pc_off[idx]; ol = pc_len[idx];
                                open_gap(idx, 2);
                                set_piece(idx, oa, oo, rem);
                                set_piece(idx + 1, 1, add_len, 1);
                                set_piece(idx + 2, oa, oo + rem, ol - rem);
                            end else begin
                                open_gap(idx, 1);
                                set_piece(idx, 1, add_len, 1);
                            end
                            add_len++;
                            n_pieces += need;
                            edited = 1;
                        end
                    end
                end
                CMD_ERASE: begin
                    hit = find_piece(pos, idx, rem);
                    if (!hit) st = ST_RANGE;
                    else if (rem == pc_len[idx] - 1) begin
                        pc_len[idx]--;
                        edited = 1;
                    end else if (rem == 0) begin
                        pc_off[idx]++;
                        pc_len[idx]--;
                        edited = 1;
                    end else if (n_pieces + 1 > NumPieces) st = ST_FULL;
                    else begin
                        oa = pc_add[idx]; oo = pc_off[idx]; ol = pc_len[idx];
                        open_gap(idx, 1);
                        set_piece(idx, oa, oo, rem);
                        set_piece(idx + 1, oa, oo + rem + 1, ol - rem - 1);
                        n_pieces++;
                        edited = 1;
                    end
                end
                default: begin
                    hit = find_piece(pos, idx, rem);
                    if (!hit) st = ST_RANGE;
                    else dout = pc_add[idx] ? add_mem[pc_off[idx] + rem]
                                            : orig_mem[pc_off[idx] + rem];
                end
            endcase
            case (st)
                ST_OK:    n_ok++;
                ST_RANGE: n_range++;
                ST_FULL:  n_full++;
                default:  n_edit++;
            endcase
            want_status.insert(want_status.size(), st);
            want_byte.insert(want_byte.size(), dout);
        endfunction

        task report(string what);
            $display("[%0t] mismatch: %s", $time, what);
            errors++;
        endtask

        // Called once per accepted result beat.
        task check_result(logic [1:0] st, logic [7:0] dout);
            t_status    ws;
            logic [7:0] wb;
            results_seen++;
            if (want_status.size() == 0) begin
                report($sformatf("unexpected result status=%0d byte=%02h", st, dout));
                return;
            end
            ws = want_status.pop_front();
            wb = want_byte.pop_front();
            if (st !== ws)
                report($sformatf("result %0d status %0d, want %0d", results_seen, st, ws));
            if (dout !== wb)
                report($sformatf("result %0d byte %02h, want %02h", results_seen, dout, wb));
        endtask
    endclass

    logic        i_clk;
    logic        i_rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [23:0] s_axis_tdata;   // command[1:0], position[15:2], byte_in[23:16]
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [15:0] m_axis_tdata;   // status[1:0], byte_out[9:2], zero[15:10]

    text_scoreboard sb;
    bit  calm;          // no sender gaps while set
    bit  hold_request;  // asks the receiver for one long stall
    int  idle_cycles;

    piece_table_text_store u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // One beat in; valid stays up across back-to-back beats.
    task automatic send_cmd(t_cmd cmd, int pos, logic [7:0] din);
        int gap;
        gap = calm ? 0 : pick_gap();
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {din, pos[13:0], cmd};
        do @(posedge i_clk); while (!s_axis_tready);
        sb.note_command(cmd, pos, din);
    endtask

    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
    endtask

    // Receiver: checks on handshake, then picks next tready.
    initial begin : receiver
        int hold;
        hold = 0;
        m_axis_tready = 1'b0;
        @(posedge i_rst_n);
        forever begin
            @(posedge i_clk);
            if (m_axis_tvalid && m_axis_tready)
                sb.check_result(m_axis_tdata[1:0], m_axis_tdata[9:2]);
            if (hold_request) begin
                hold_request = 0;
                hold = LongStall;
            end else if (hold == 0 && !calm && $urandom_range(0, 99) < 35) begin
                hold = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 50)
                                                   : $urandom_range(1, 3);
            end
            if (hold > 0) begin
                hold--;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    // Watchdog on cycles with no beat on either side.
    initial begin
        idle_cycles = 0;
        forever begin
            @(posedge i_clk);
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= IdleLimit) begin
                $display("watchdog: no beat for %0d cycles", IdleLimit);
                $display("TB_ERROR");
                $finish;
            end
        end
    end

    initial begin : stimulus
        int   pos, len, r;
        t_cmd cmd;
        sb = new();
        calm = 0;
        hold_request = 0;
        i_rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Empty text: everything positional is out of range.
        send_cmd(CMD_READ, 0, 8'h00);
        send_cmd(CMD_INSERT, 1, 8'h11);
        send_cmd(CMD_ERASE, 0, 8'h00);
        send_cmd(CMD_READ, 16383, 8'hFF);

        // Load the original text back to back.
        calm = 1;
        for (int i = 0; i < FillBytes; i++)
            send_cmd(CMD_LOAD, $urandom_range(0, 16383),
                     (i == 0) ? 8'h00 : (i == FillBytes - 1) ? 8'hFF : 8'($urandom));
        calm = 0;

        // Directed edits over the loaded text.
        send_cmd(CMD_READ, 0, 8'h00);
        send_cmd(CMD_READ, FillBytes - 1, 8'h00);
        send_cmd(CMD_READ, FillBytes, 8'h00);
        send_cmd(CMD_INSERT, FillBytes + 1, 8'h5A);  // past end
        send_cmd(CMD_INSERT, 0, 8'hFF);              // front boundary
        send_cmd(CMD_INSERT, FillBytes + 1, 8'h00);  // append at end
        send_cmd(CMD_INSERT, 100, 8'h3C);            // split inside a piece
        send_cmd(CMD_INSERT, 101, 8'hC3);            // on a boundary
        send_cmd(CMD_ERASE, 0, 8'h00);               // one-byte piece to zero length
        send_cmd(CMD_READ, 0, 8'h00);
        send_cmd(CMD_ERASE, 99, 8'h00);              // last byte of a piece
        send_cmd(CMD_ERASE, 100, 8'h00);             // first byte of a piece
        send_cmd(CMD_ERASE, 200, 8'h00);             // split by erase
        send_cmd(CMD_LOAD, 0, 8'h77);                // load after edit
        send_cmd(CMD_ERASE, 16383, 8'h00);
        send_cmd(CMD_READ, 98, 8'h00);
        send_cmd(CMD_READ, 99, 8'h00);
        send_cmd(CMD_READ, 200, 8'h00);

        // Random mix; inserts and erases fill the table and then hit the full case.
        for (int n = 0; n < RandItems; n++) begin
            if (n % 150 == 0) calm = ($urandom_range(0, 3) == 0);
            if (n == 300) hold_request = 1;
            if (n == 800) drain_results();
            r = $urandom_range(0, 99);
            cmd = (r < 10) ? CMD_LOAD : (r < 35) ? CMD_INSERT : (r < 60) ? CMD_ERASE
                                                                         : CMD_READ;
            len = sb.text_len();
            pos = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 16383)
                                              : $urandom_range(0, len + 1);
            send_cmd(cmd, pos, 8'($urandom));
        end
        calm = 0;

        drain_results();
        repeat (20) @(posedge i_clk);
        $display("covered %0d results: %0d ok, %0d out of range, %0d full, %0d load after edit",
                 sb.results_seen, sb.n_ok, sb.n_range, sb.n_full, sb.n_edit);
        $display("final text %0d bytes in %0d pieces, %0d bytes added",
                 sb.text_len(), sb.n_pieces, sb.add_len);
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end
endmodule

[files.f]
src/pt_pkg.sv
src/pt_cell.sv
src/pt_locate.sv
src/piece_table_text_store.sv
tb/sv/tb_piece_table_text_store.sv
